// File: rtl/core/lokt_pkg.sv
// shared types, codes and widths for the recency-ordered key table
// no dependencies; used by every module of the block
package lokt_pkg;

    localparam int KEY_W     = 32;
    localparam int VALUE_W   = 32;
    localparam int OP_W      = 3;
    localparam int RANK_W    = 6;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 7;
    localparam int ENTRIES_DEF = 64;

    typedef enum logic [OP_W-1:0] {
        OP_SET    = 3'd0,
        OP_LOOKUP = 3'd1,
        OP_TOUCH  = 3'd2,
        OP_REMOVE = 3'd3,
        OP_GET    = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // what every cell does on the apply cycle
    typedef enum logic [1:0] {
        MODE_HOLD    = 2'd0,
        MODE_INSERT  = 2'd1,
        MODE_PROMOTE = 2'd2,
        MODE_REMOVE  = 2'd3
    } t_cell_mode;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic [RANK_W-1:0]  rank_from_oldest;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KEY_W-1:0]    key_out;
        logic [VALUE_W-1:0]  value_out;
        logic [COUNT_W-1:0]  entry_count;
    } t_rsp;

endpackage

// File: rtl/core/lru_ordered_key_table_core.sv
// top level of the recency-ordered key table: row of cells kept in recency order
// depends on lokt_pkg, lokt_cell, lokt_collect
//
//  channel | direction | handshake                    | word
//  in      | input     | i_in_valid / o_in_ready      | i_in_data  (t_req)
//  out     | output    | o_out_valid / i_out_ready    | o_out_data (t_rsp)
//
// one word at a time: the accept edge registers the search across all cells,
// then the apply state shifts the cell row and loads the output register
// cell 0 is most recent; occupied cells are always 0 .. count-1
// a full output register holds the apply cycle until the word is taken
// reset clears only the count and handshake state, no clearing pass
module lru_ordered_key_table_core import lokt_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_req i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_rsp o_out_data
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int RW    = (CNT_W > RANK_W) ? CNT_W : RANK_W;
    localparam int EXT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_APPLY = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic r_out_valid;
    t_rsp r_out;

    // request and search result held for the apply cycle
    logic [OP_W-1:0]    r_op;
    logic [KEY_W-1:0]   r_key;
    logic [VALUE_W-1:0] r_val;
    logic               r_hit;
    logic [IDX_W-1:0]   r_pos;
    logic [KEY_W-1:0]   r_fkey;
    logic [VALUE_W-1:0] r_fval;

    logic [KEY_W-1:0]   cell_key [ENTRIES];
    logic [VALUE_W-1:0] cell_val [ENTRIES];
    logic [ENTRIES-1:0] cell_sel;

    logic               in_acc, go;
    logic               find_rank, rank_ok;
    logic [RW-1:0]      rank_ext, count_ext;
    logic [IDX_W-1:0]   want;
    logic               c_hit;
    logic [IDX_W-1:0]   c_pos;
    logic [KEY_W-1:0]   c_key;
    logic [VALUE_W-1:0] c_val;
    t_cell_mode         mode, cell_mode;
    t_status            st;
    logic [KEY_W-1:0]   kout;
    logic [VALUE_W-1:0] vout;
    logic [VALUE_W-1:0] front_val;
    logic [EXT_W-1:0]   count_out;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign go         = (r_state == S_APPLY) && (!r_out_valid || i_out_ready);

    // rank counted from the oldest maps to cell count-1-rank
    assign find_rank = (i_in_data.op == OP_GET);
    assign rank_ext  = RW'(i_in_data.rank_from_oldest);
    assign count_ext = RW'(r_count);
    assign rank_ok   = rank_ext < count_ext;
    assign want      = IDX_W'(count_ext - RW'(1) - rank_ext);

    assign front_val = (r_op == OP_TOUCH) ? r_fval : r_val;
    assign cell_mode = go ? mode : MODE_HOLD;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        logic [KEY_W-1:0]   left_key, right_key;
        logic [VALUE_W-1:0] left_val, right_val;

        if (g == 0) begin : g_head
            assign left_key = r_key;
            assign left_val = front_val;
        end else begin : g_mid
            assign left_key = cell_key[g-1];
            assign left_val = cell_val[g-1];
        end
        if (g == ENTRIES - 1) begin : g_tail
            assign right_key = cell_key[g];
            assign right_val = cell_val[g];
        end else begin : g_body
            assign right_key = cell_key[g+1];
            assign right_val = cell_val[g+1];
        end

        lokt_cell #(
            .IDX_W (IDX_W),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_idx       (IDX_W'(g)),
            .i_count     (r_count),
            .i_probe_key (i_in_data.key),
            .i_find_rank (find_rank),
            .i_rank_ok   (rank_ok),
            .i_want      (want),
            .o_sel       (cell_sel[g]),
            .i_mode      (cell_mode),
            .i_pos       (r_pos),
            .i_left_key  (left_key),
            .i_left_val  (left_val),
            .i_right_key (right_key),
            .i_right_val (right_val),
            .o_key       (cell_key[g]),
            .o_val       (cell_val[g])
        );
    end

    lokt_collect #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_collect (
        .i_sel  (cell_sel),
        .i_keys (cell_key),
        .i_vals (cell_val),
        .o_hit  (c_hit),
        .o_pos  (c_pos),
        .o_key  (c_key),
        .o_val  (c_val)
    );

    always_comb begin
        mode    = MODE_HOLD;
        st      = ST_MISS;
        kout    = '0;
        vout    = '0;
        n_count = r_count;
        unique case (r_op)
            OP_SET: begin
                if (r_hit) begin
                    mode = MODE_PROMOTE;
                    st   = ST_OK;
                end else if (r_count == CNT_W'(ENTRIES)) begin
                    st = ST_FULL;
                end else begin
                    mode    = MODE_INSERT;
                    st      = ST_OK;
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_LOOKUP: begin
                if (r_hit) begin
                    st   = ST_OK;
                    vout = r_fval;
                end
            end
            OP_TOUCH: begin
                if (r_hit) begin
                    mode = MODE_PROMOTE;
                    st   = ST_OK;
                end
            end
            OP_REMOVE: begin
                if (r_hit) begin
                    mode    = MODE_REMOVE;
                    st      = ST_OK;
                    n_count = r_count - CNT_W'(1);
                end
            end
            OP_GET: begin
                if (r_hit) begin
                    st   = ST_OK;
                    kout = r_fkey;
                    vout = r_fval;
                end
            end
            default: begin
            end
        endcase
    end

    assign count_out = EXT_W'(n_count);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_acc) n_state = S_APPLY;
            S_APPLY: if (go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (go) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op   <= i_in_data.op;
            r_key  <= i_in_data.key;
            r_val  <= i_in_data.value;
            r_hit  <= c_hit;
            r_pos  <= c_pos;
            r_fkey <= c_key;
            r_fval <= c_val;
        end
        if (go) begin
            r_out.status      <= st;
            r_out.key_out     <= kout;
            r_out.value_out   <= vout;
            r_out.entry_count <= count_out[COUNT_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: rtl/core/lokt_cell.sv
// one cell of the recency row: holds the entry at one recency position
// depends on lokt_pkg; neighbors hand key and value through on shifts
module lokt_cell import lokt_pkg::*; #(
    parameter int IDX_W = 6,
    parameter int CNT_W = 7
) (
    input  logic               i_clk,
    input  logic [IDX_W-1:0]   i_idx,
    input  logic [CNT_W-1:0]   i_count,
    // search
    input  logic [KEY_W-1:0]   i_probe_key,
    input  logic               i_find_rank,
    input  logic               i_rank_ok,
    input  logic [IDX_W-1:0]   i_want,
    output logic               o_sel,
    // shift
    input  t_cell_mode         i_mode,
    input  logic [IDX_W-1:0]   i_pos,
    input  logic [KEY_W-1:0]   i_left_key,
    input  logic [VALUE_W-1:0] i_left_val,
    input  logic [KEY_W-1:0]   i_right_key,
    input  logic [VALUE_W-1:0] i_right_val,
    output logic [KEY_W-1:0]   o_key,
    output logic [VALUE_W-1:0] o_val
);

    logic [KEY_W-1:0]   r_key;
    logic [VALUE_W-1:0] r_val;
    logic [KEY_W-1:0]   n_key;
    logic [VALUE_W-1:0] n_val;
    logic               live;

    // cells are packed: position below the count means occupied
    assign live  = {1'b0, i_idx} < (IDX_W + 1)'(i_count);
    assign o_sel = i_find_rank ? (i_rank_ok && i_idx == i_want)
                               : (live && r_key == i_probe_key);

    always_comb begin
        n_key = r_key;
        n_val = r_val;
        unique case (i_mode)
            MODE_INSERT: begin
                n_key = i_left_key;
                n_val = i_left_val;
            end
            MODE_PROMOTE: begin
                if (i_idx <= i_pos) begin
                    n_key = i_left_key;
                    n_val = i_left_val;
                end
            end
            MODE_REMOVE: begin
                if (i_idx >= i_pos) begin
                    n_key = i_right_key;
                    n_val = i_right_val;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_val <= n_val;
    end

    assign o_key = r_key;
    assign o_val = r_val;

endmodule

// File: rtl/core/lokt_collect.sv
// gathers the one selected cell out of the row: hit flag, position, key, value
// depends on lokt_pkg; at most one cell selects at a time
module lokt_collect import lokt_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF,
    parameter int IDX_W   = 6
) (
    input  logic [ENTRIES-1:0] i_sel,
    input  logic [KEY_W-1:0]   i_keys [ENTRIES],
    input  logic [VALUE_W-1:0] i_vals [ENTRIES],
    output logic               o_hit,
    output logic [IDX_W-1:0]   o_pos,
    output logic [KEY_W-1:0]   o_key,
    output logic [VALUE_W-1:0] o_val
);

    // one-hot select, so a masked or-reduction is the mux
    always_comb begin
        o_pos = '0;
        o_key = '0;
        o_val = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            o_pos = o_pos | ({IDX_W{i_sel[i]}} & IDX_W'(i));
            o_key = o_key | ({KEY_W{i_sel[i]}} & i_keys[i]);
            o_val = o_val | ({VALUE_W{i_sel[i]}} & i_vals[i]);
        end
    end

    assign o_hit = |i_sel;

endmodule
